### rtl/core/sync_framed_packet_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// Sync-framed packet parser assertion macros
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAMED_PACKET_PARSER_UNIT_ASSERT_SVH
`define SYNC_FRAMED_PACKET_PARSER_UNIT_ASSERT_SVH

// Check a property while out of reset.
`define SFPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define SFPP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/sfpp_pkg.sv
// ----------------------------------------------------------------------------
// sfpp_pkg
// Types and constants of the sync-framed packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sfpp_pkg;

  localparam int unsigned PAYLOAD_BYTES = 9;
  localparam int unsigned CNT_W         = $clog2(PAYLOAD_BYTES + 1);
  localparam int unsigned LAST_IDX      = PAYLOAD_BYTES - 1;

  localparam logic [7:0] SYNC_BYTE    = 8'hAA;
  localparam logic [7:0] TRAILER_BYTE = 8'hFF;
  localparam logic [7:0] TARGET_FLAG  = 8'h01;

  // parse phase codes
  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_SYNC2  = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [7:0]  x_direction;
    logic [7:0]  y_direction;
    logic [15:0] x_distance;
    logic [15:0] y_distance;
    logic [7:0]  status_flag;
    logic        target_detected;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/sfpp_stream_if.sv
// ----------------------------------------------------------------------------
// sfpp_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfpp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/sync_framed_packet_parser_unit.sv
// ----------------------------------------------------------------------------
// sync_framed_packet_parser_unit
// Takes one received byte per transfer and hunts for the sync pair AA AA.
// The nine bytes after the sync are the payload; a payload that ends in
// FF FF yields one result decoded from payload bytes 0..6, any other frame
// is dropped without a result. A byte that breaks the sync pair sends the
// parser back to hunting and is not itself taken as a first sync byte.
// Rate: one byte per cycle, but the input stalls only while the output register
// holds a result the sink has not taken. The result appears in that register
// in the cycle after the last payload byte transfers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sync_framed_packet_parser_unit_assert.svh"

module sync_framed_packet_parser_unit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  sfpp_stream_if.sink        in_s,
  sfpp_stream_if.source      out_m
);

  logic [1:0]                    phase_r, phase_nxt;
  logic [sfpp_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [7:0]                    store_r [sfpp_pkg::PAYLOAD_BYTES];
  logic                          out_valid_r, out_valid_nxt;
  sfpp_pkg::result_t             out_data_r;
  sfpp_pkg::result_t             result;

  logic       in_xfer;
  logic       out_xfer;
  logic [7:0] rx;
  logic       store_en;
  logic       frame_end;
  logic       frame_good;

  assign in_s.ready  = !out_valid_r || out_m.ready;
  assign in_xfer     = in_s.valid && in_s.ready;
  assign out_xfer    = out_valid_r && out_m.ready;
  assign rx          = in_s.data.rx_byte;

  assign store_en    = in_xfer && (phase_r == sfpp_pkg::PH_DATA) &&
                       (count_r < sfpp_pkg::CNT_W'(sfpp_pkg::PAYLOAD_BYTES));
  // last payload byte arrives now; trailer is the stored byte plus this one
  assign frame_end   = in_xfer && (phase_r == sfpp_pkg::PH_DATA) &&
                       (count_r == sfpp_pkg::CNT_W'(sfpp_pkg::LAST_IDX));
  assign frame_good  = frame_end &&
                       (store_r[sfpp_pkg::LAST_IDX-1] == sfpp_pkg::TRAILER_BYTE) &&
                       (rx == sfpp_pkg::TRAILER_BYTE);

  always_comb begin
    result.x_direction     = store_r[0];
    result.y_direction     = store_r[1];
    result.x_distance      = {store_r[2], store_r[3]};
    result.y_distance      = {store_r[4], store_r[5]};
    result.status_flag     = store_r[6];
    result.target_detected = (store_r[6] == sfpp_pkg::TARGET_FLAG);
  end

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    if (in_xfer) begin
      unique case (phase_r)
        sfpp_pkg::PH_SYNC2: begin
          count_nxt = '0;
          phase_nxt = (rx == sfpp_pkg::SYNC_BYTE) ? sfpp_pkg::PH_DATA : sfpp_pkg::PH_HUNT;
        end
        sfpp_pkg::PH_DATA: begin
          if (count_r >= sfpp_pkg::CNT_W'(sfpp_pkg::LAST_IDX)) begin
            phase_nxt = sfpp_pkg::PH_HUNT;
            count_nxt = '0;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        sfpp_pkg::PH_HUNT, sfpp_pkg::PH_UNUSED: begin
          phase_nxt = (rx == sfpp_pkg::SYNC_BYTE) ? sfpp_pkg::PH_SYNC2 : sfpp_pkg::PH_HUNT;
        end
        default: begin
          phase_nxt = sfpp_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (frame_good) begin
      out_valid_nxt = 1'b1;
    end else if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= sfpp_pkg::PH_HUNT;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload bytes, written at the current count
  always_ff @(posedge clk) begin
    for (int unsigned i = 0; i < sfpp_pkg::PAYLOAD_BYTES; i++) begin
      if (store_en && (count_r == sfpp_pkg::CNT_W'(i))) begin
        store_r[i] <= rx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_good) begin
      out_data_r <= result;
    end
  end

  assign out_m.valid = out_valid_r;
  assign out_m.data  = out_data_r;

  `SFPP_ASSERT(a_result_follows_frame_end,
    $rose(out_valid_r) |-> $past(frame_end), "result without a completed frame")
  `SFPP_ASSERT(a_count_in_range,
    count_r < sfpp_pkg::CNT_W'(sfpp_pkg::PAYLOAD_BYTES), "payload count out of range")
  `SFPP_ASSERT(a_count_idle_outside_data,
    phase_r != sfpp_pkg::PH_DATA |-> count_r == '0, "payload count nonzero outside data")
  `SFPP_ASSERT(a_phase_code_used,
    phase_r != sfpp_pkg::PH_UNUSED, "unused parse phase reached")
  `SFPP_ASSERT(a_target_matches_flag,
    out_valid_r |-> out_data_r.target_detected == (out_data_r.status_flag == sfpp_pkg::TARGET_FLAG),
    "target bit disagrees with flag")
  `SFPP_ASSERT_ALWAYS(a_reset_clears_output,
    !rst_n |=> !out_valid_r, "output valid after reset")

endmodule

`default_nettype wire

### bench/sync_framed_packet_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_framed_packet_parser_unit_tb
// Feeds byte streams to the parser: a few hand-built frames first, then mostly
// well-formed frames with random content mixed with broken sync pairs, bad
// trailers and loose noise. A scoreboard tracks the hunt/sync/payload state
// for every accepted byte and checks each decoded result against the oldest
// frame it predicted. The sender bursts with random gaps, and the sink
// stalls on its own pattern, including one long hold-off.
// ----------------------------------------------------------------------------

module sync_framed_packet_parser_unit_tb;

  typedef enum int {
    PACE_FULL,
    PACE_RANDOM,
    PACE_PATTERN
  } pace_mode_t;

  class frame_result_scoreboard;
    logic [1:0]          parse_phase;
    int unsigned         payload_count;
    logic [7:0]          payload_bytes [sfpp_pkg::PAYLOAD_BYTES];
    sfpp_pkg::result_t   pending_results [$];
    int unsigned         mismatches;

    function new();
      parse_phase   = sfpp_pkg::PH_HUNT;
      payload_count = 0;
      mismatches    = 0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // Advance the parse state by one accepted byte; queue a result when a
    // frame closes with a good trailer.
    task note_rx_byte(logic [7:0] rx);
      sfpp_pkg::result_t decoded;
      case (parse_phase)
        sfpp_pkg::PH_SYNC2: begin
          if (rx == sfpp_pkg::SYNC_BYTE) begin
            payload_count = 0;
            parse_phase   = sfpp_pkg::PH_DATA;
          end else begin
            parse_phase = sfpp_pkg::PH_HUNT;
          end
        end
        sfpp_pkg::PH_DATA: begin
          if (payload_count < sfpp_pkg::PAYLOAD_BYTES) begin
            payload_bytes[payload_count] = rx;
            payload_count++;
          end
          if (payload_count >= sfpp_pkg::PAYLOAD_BYTES) begin
            parse_phase   = sfpp_pkg::PH_HUNT;
            payload_count = 0;
            if (payload_bytes[sfpp_pkg::LAST_IDX - 1] == sfpp_pkg::TRAILER_BYTE &&
                payload_bytes[sfpp_pkg::LAST_IDX] == sfpp_pkg::TRAILER_BYTE) begin
              decoded.x_direction     = payload_bytes[0];
              decoded.y_direction     = payload_bytes[1];
              decoded.x_distance      = {payload_bytes[2], payload_bytes[3]};
              decoded.y_distance      = {payload_bytes[4], payload_bytes[5]};
              decoded.status_flag     = payload_bytes[6];
              decoded.target_detected = (payload_bytes[6] == sfpp_pkg::TARGET_FLAG);
              pending_results.push_back(decoded);
            end
          end
        end
        // unused phase code behaves like hunting
        default: parse_phase = (rx == sfpp_pkg::SYNC_BYTE) ? sfpp_pkg::PH_SYNC2
                                                          : sfpp_pkg::PH_HUNT;
      endcase
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task check_result(sfpp_pkg::result_t got);
      sfpp_pkg::result_t want;
      if (pending_results.size() == 0) begin
        report("result transfer with no frame pending");
        return;
      end
      want = pending_results.pop_front();
      compare_field("x_direction", got.x_direction, want.x_direction);
      compare_field("y_direction", got.y_direction, want.y_direction);
      compare_field("x_distance", got.x_distance, want.x_distance);
      compare_field("y_distance", got.y_distance, want.y_distance);
      compare_field("status_flag", got.status_flag, want.status_flag);
      compare_field("target_detected", got.target_detected, want.target_detected);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  sfpp_stream_if #(.T(sfpp_pkg::rx_item_t)) in_if ();
  sfpp_stream_if #(.T(sfpp_pkg::result_t))  out_if ();

  sync_framed_packet_parser_unit i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if),
    .out_m (out_if)
  );

  frame_result_scoreboard sb = new();
  logic [7:0]             rx_stream [$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [7:0] non_sync_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == sfpp_pkg::SYNC_BYTE) ? ~b : b;
  endfunction

  // Lean on the values that matter to the parser: zero, trailer and sync.
  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return sfpp_pkg::TRAILER_BYTE;
      2:       return sfpp_pkg::SYNC_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.data);
      if (in_if.valid && in_if.ready)
        sb.note_rx_byte(in_if.data.rx_byte);
    end
  end

  initial begin : sink_pacing
    int unsigned cycles;
    int unsigned stretch;
    int unsigned k;
    pace_mode_t  mode;
    bit          held_off;
    cycles   = 0;
    held_off = 1'b0;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      mode    = pace_mode_t'($urandom_range(0, 2));
      stretch = $urandom_range(16, 64);
      for (k = 0; k < stretch; k++) begin
        case (mode)
          PACE_FULL:   out_if.ready <= 1'b1;
          PACE_RANDOM: out_if.ready <= ($urandom_range(0, 2) != 0);
          default:     out_if.ready <= ((k % 8) < 5);
        endcase
        @(posedge clk);
        cycles++;
      end
      // hold off long enough for the parser to back up onto its input
      if (!held_off && cycles >= 80) begin
        out_if.ready <= 1'b0;
        repeat (120) @(posedge clk);
        held_off = 1'b1;
      end
    end
  end

  initial begin : source_side
    int unsigned idx;
    int unsigned burst;
    int unsigned gap;
    int unsigned good_frames;
    int unsigned pick;
    int unsigned i;
    logic [7:0]  frame [sfpp_pkg::PAYLOAD_BYTES];

    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    rst_n       <= 1'b0;

    // all-max frame with target flag; then a broken sync, sync bytes inside
    // a mostly zero payload and a bad trailer
    rx_stream = {sfpp_pkg::SYNC_BYTE, sfpp_pkg::SYNC_BYTE,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, sfpp_pkg::TARGET_FLAG,
                 sfpp_pkg::TRAILER_BYTE, sfpp_pkg::TRAILER_BYTE,
                 8'h00, sfpp_pkg::SYNC_BYTE, 8'h55, sfpp_pkg::SYNC_BYTE,
                 sfpp_pkg::SYNC_BYTE,
                 8'h00, 8'h00, 8'h00, 8'h00, sfpp_pkg::SYNC_BYTE,
                 sfpp_pkg::SYNC_BYTE, 8'h00,
                 8'hFE, sfpp_pkg::TRAILER_BYTE};
    good_frames = 1;

    while (rx_stream.size() < 525 || good_frames < 40) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        if ($urandom_range(0, 3) == 0)
          rx_stream.push_back(non_sync_byte());
        rx_stream.push_back(sfpp_pkg::SYNC_BYTE);
        rx_stream.push_back(sfpp_pkg::SYNC_BYTE);
        for (i = 0; i < sfpp_pkg::PAYLOAD_BYTES; i++)
          frame[i] = payload_byte();
        case ($urandom_range(0, 3))
          0:       frame[6] = sfpp_pkg::TARGET_FLAG;
          1:       frame[6] = 8'h00;
          default: ;
        endcase
        if ($urandom_range(0, 7) != 0) begin
          frame[sfpp_pkg::LAST_IDX - 1] = sfpp_pkg::TRAILER_BYTE;
          frame[sfpp_pkg::LAST_IDX]     = sfpp_pkg::TRAILER_BYTE;
          good_frames++;
        end else begin
          if ($urandom_range(0, 1) == 0)
            frame[sfpp_pkg::LAST_IDX - 1] = sfpp_pkg::TRAILER_BYTE;
          if (frame[sfpp_pkg::LAST_IDX - 1] == sfpp_pkg::TRAILER_BYTE &&
              frame[sfpp_pkg::LAST_IDX] == sfpp_pkg::TRAILER_BYTE)
            frame[sfpp_pkg::LAST_IDX] = 8'hFE;
        end
        for (i = 0; i < sfpp_pkg::PAYLOAD_BYTES; i++)
          rx_stream.push_back(frame[i]);
      end else if (pick < 88) begin
        rx_stream.push_back(sfpp_pkg::SYNC_BYTE);
        rx_stream.push_back(non_sync_byte());
      end else begin
        repeat ($urandom_range(1, 4)) rx_stream.push_back(payload_byte());
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    idx = 0;
    while (idx < rx_stream.size()) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && idx < rx_stream.size()) begin
        in_if.valid <= 1'b1;
        in_if.data  <= sfpp_pkg::rx_item_t'(rx_stream[idx]);
        do @(posedge clk); while (!in_if.ready);
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_if.valid <= 1'b0;

    // let the scoreboard see the last transfer before draining
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // timeout set far beyond the slowest correct run
  initial begin : watchdog
    #2_400_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
